// File: hw/rtl/hcs_pkg.sv
// Shared constants and mod-26 arithmetic helpers for the 2x2 Hill cipher stream.
package hcs_pkg;

  localparam int unsigned ValW = 5;

  localparam logic [ValW-1:0] Modulus    = 5'd26;
  localparam logic [ValW-1:0] PadLetter  = 5'd23;
  localparam logic [6:0]      LetterBase = 7'd65;

  // Configuration register indexes
  localparam logic [2:0] REG_KEY_TL  = 3'd0;
  localparam logic [2:0] REG_KEY_TR  = 3'd1;
  localparam logic [2:0] REG_KEY_BL  = 3'd2;
  localparam logic [2:0] REG_KEY_BR  = 3'd3;
  localparam logic [2:0] REG_DECRYPT = 3'd4;

  // Result status codes
  localparam logic [1:0] STATUS_LETTER  = 2'd0;
  localparam logic [1:0] STATUS_END     = 2'd1;
  localparam logic [1:0] STATUS_BLOCKED = 2'd2;

  // Key register reset values
  localparam logic [ValW-1:0] KeyRstTl = 5'd6;
  localparam logic [ValW-1:0] KeyRstTr = 5'd24;
  localparam logic [ValW-1:0] KeyRstBl = 5'd1;
  localparam logic [ValW-1:0] KeyRstBr = 5'd13;

  // One step of the shared unit: ((dbl ? 2r : r) + term + addend) mod 26.
  // Inputs stay small enough that the sum is below 104.
  function automatic logic [ValW-1:0] mod26_step(input logic [ValW-1:0] r,
                                                 input logic            dbl,
                                                 input logic [ValW-1:0] term,
                                                 input logic [ValW-1:0] addend);
    logic [6:0] s;
    s = (dbl ? {1'b0, r, 1'b0} : {2'b00, r}) + {2'b00, term} + {2'b00, addend};
    priority if (s >= 7'd78) begin
      mod26_step = 5'(s - 7'd78);
    end else if (s >= 7'd52) begin
      mod26_step = 5'(s - 7'd52);
    end else if (s >= 7'd26) begin
      mod26_step = 5'(s - 7'd26);
    end else begin
      mod26_step = s[ValW-1:0];
    end
  endfunction

  // Reduce a 5-bit value into 0..25.
  function automatic logic [ValW-1:0] red26(input logic [ValW-1:0] k);
    red26 = (k >= Modulus) ? (k - Modulus) : k;
  endfunction

  // Additive inverse of a value already in 0..25.
  function automatic logic [ValW-1:0] neg26(input logic [ValW-1:0] k);
    neg26 = (k == '0) ? '0 : (Modulus - k);
  endfunction

endpackage

// File: hw/rtl/hill_cipher_2x2_stream.sv
// Streaming 2x2 Hill cipher (mod 26) with serial key inversion and pair multiply.
//
// Takes one character per transaction; non-letters are dropped and lowercase is folded to
// uppercase. Letters pair up, and each pair is multiplied by the 2x2 key (encrypt) or its
// inverse mod 26 (decrypt), producing two uppercase letter transactions. An end-of-text
// transaction pads a lone letter with 'X', or else returns one end marker (status 1); in
// decrypt mode with a non-invertible key letters are dropped and end returns status 2.
// Sequence: a non-letter, a first letter of a pair, or an end without pending letter is
// handled in the idle state. A completed pair runs through the multiplier, and then the
// output states S_OUT0 and S_OUT1 hand out its results. After reset and after every key
// or mode register write the active matrix is rebuilt before any character is taken: a
// start step, the determinant, the inverse search, and in decrypt mode the inverse matrix.
// All these steps use one shared mod-26 unit that multiplies one operand bit per cycle
// (four products per matrix) under a small sequencer.
module hill_cipher_2x2_stream (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write port
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_index_i,
  input  logic [4:0] cfg_data_i,
  // input channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       kind_i,
  input  logic [7:0] char_code_i,
  // output channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [6:0] letter_code_o,
  output logic [1:0] status_o,
  output logic       last_o
);
  import hcs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DET,
    S_SEARCH,
    S_INV,
    S_MUL,
    S_OUT0,
    S_OUT1
  } state_e;

  localparam logic [2:0] BitMsb = 3'(ValW - 1);

  state_e          state_q;

  // configuration registers
  logic [ValW-1:0] key_q [4];
  logic            decrypt_q;

  // key preparation results
  logic [ValW-1:0] active_q [4];
  logic            key_ready_q;
  logic            invertible_q;
  logic [ValW-1:0] inv_q;

  // pairing state
  logic            pending_valid_q;
  logic [ValW-1:0] pending_value_q;
  logic [ValW-1:0] p0_q;
  logic [ValW-1:0] p1_q;
  logic            pair_last_q;

  // sequencer counters and shared unit accumulator
  logic [1:0]      pidx_q;
  logic [2:0]      bit_q;
  logic [ValW-1:0] r_q;
  logic [ValW-1:0] x_q;
  logic [ValW-1:0] res_q [4];

  // output register
  logic            out_valid_q;
  logic [6:0]      letter_q;
  logic [1:0]      status_q;
  logic            last_q;

  logic [ValW-1:0] kr [4];
  logic [ValW-1:0] a_sel;
  logic [ValW-1:0] b_sel;
  logic [ValW-1:0] r_in;
  logic            dbl;
  logic [ValW-1:0] term;
  logic [ValW-1:0] addend;
  logic [ValW-1:0] unit_out;
  logic            prod_last;
  logic            prod_done;
  logic            search_hit;
  logic            search_end;
  logic            out_free;
  logic            in_accept;
  logic            blocked;
  logic            is_upper;
  logic            is_lower;
  logic [ValW-1:0] char_val;
  logic [7:0]      char_off;

  // Key entries reduced into 0..25
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      kr[i] = red26(key_q[i]);
    end
  end

  // Operand selection for the shared unit
  always_comb begin
    a_sel = '0;
    b_sel = '0;
    unique case (state_q)
      S_DET: begin
        // det = k0*k3 + k1*(-k2)
        a_sel = pidx_q[0] ? kr[1] : kr[0];
        b_sel = pidx_q[0] ? neg26(kr[2]) : kr[3];
      end
      S_INV: begin
        b_sel = inv_q;
        unique case (pidx_q)
          2'd0:    a_sel = kr[3];
          2'd1:    a_sel = neg26(kr[1]);
          2'd2:    a_sel = neg26(kr[2]);
          default: a_sel = kr[0];
        endcase
      end
      S_MUL: begin
        a_sel = active_q[pidx_q];
        b_sel = pidx_q[0] ? p1_q : p0_q;
      end
      default: begin
        a_sel = '0;
        b_sel = '0;
      end
    endcase
  end

  always_comb begin
    prod_last = (bit_q == 3'd0);
    prod_done = prod_last && (pidx_q == ((state_q == S_DET) ? 2'd1 : 2'd3));
    if (state_q == S_SEARCH) begin
      // step the running multiple det*x by one more det
      r_in   = r_q;
      dbl    = 1'b0;
      term   = res_q[1];
      addend = '0;
    end else begin
      // MSB-first shift-add multiply; outside S_INV odd products fold in the even partner
      r_in   = (bit_q == BitMsb) ? '0 : r_q;
      dbl    = 1'b1;
      term   = b_sel[bit_q] ? a_sel : '0;
      addend = (prod_last && pidx_q[0] && (state_q != S_INV)) ? res_q[{pidx_q[1], 1'b0}] : '0;
    end
    unit_out   = mod26_step(r_in, dbl, term, addend);
    search_hit = (unit_out == 5'd1);
    search_end = search_hit || (x_q == 5'd24);
  end

  // Character decode
  always_comb begin
    is_upper = (char_code_i >= 8'd65) && (char_code_i <= 8'd90);
    is_lower = (char_code_i >= 8'd97) && (char_code_i <= 8'd122);
    char_off = is_lower ? (char_code_i - 8'd97) : (char_code_i - 8'd65);
    char_val = char_off[ValW-1:0];
  end

  assign blocked    = decrypt_q && !invertible_q;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && key_ready_q && out_free);
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      key_q[0]        <= KeyRstTl;
      key_q[1]        <= KeyRstTr;
      key_q[2]        <= KeyRstBl;
      key_q[3]        <= KeyRstBr;
      decrypt_q       <= 1'b0;
      key_ready_q     <= 1'b0;
      invertible_q    <= 1'b0;
      inv_q           <= '0;
      pending_valid_q <= 1'b0;
      pending_value_q <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      // drop the taken result; a new one below overrides this
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (!key_ready_q) begin
            state_q <= S_DET;
            pidx_q  <= 2'd0;
            bit_q   <= BitMsb;
          end else if (in_accept) begin
            if (kind_i) begin
              if (blocked) begin
                pending_valid_q <= 1'b0;
                pending_value_q <= '0;
                out_valid_q     <= 1'b1;
                letter_q        <= '0;
                status_q        <= STATUS_BLOCKED;
                last_q          <= 1'b1;
              end else if (pending_valid_q) begin
                p0_q            <= pending_value_q;
                p1_q            <= PadLetter;
                pair_last_q     <= 1'b1;
                pending_valid_q <= 1'b0;
                pending_value_q <= '0;
                state_q         <= S_MUL;
                pidx_q          <= 2'd0;
                bit_q           <= BitMsb;
              end else begin
                out_valid_q <= 1'b1;
                letter_q    <= '0;
                status_q    <= STATUS_END;
                last_q      <= 1'b1;
              end
            end else if ((is_upper || is_lower) && !blocked) begin
              if (pending_valid_q) begin
                p0_q            <= pending_value_q;
                p1_q            <= char_val;
                pair_last_q     <= 1'b0;
                pending_valid_q <= 1'b0;
                pending_value_q <= '0;
                state_q         <= S_MUL;
                pidx_q          <= 2'd0;
                bit_q           <= BitMsb;
              end else begin
                pending_valid_q <= 1'b1;
                pending_value_q <= char_val;
              end
            end
          end
        end

        S_DET, S_INV, S_MUL: begin
          r_q <= unit_out;
          if (prod_last) begin
            res_q[pidx_q] <= unit_out;
            bit_q         <= BitMsb;
            pidx_q        <= pidx_q + 2'd1;
          end else begin
            bit_q <= bit_q - 3'd1;
          end
          if (prod_done) begin
            unique case (state_q)
              S_DET: begin
                state_q <= S_SEARCH;
                r_q     <= '0;
                x_q     <= '0;
              end
              S_INV: begin
                active_q[0] <= res_q[0];
                active_q[1] <= res_q[1];
                active_q[2] <= res_q[2];
                active_q[3] <= unit_out;
                key_ready_q <= 1'b1;
                state_q     <= S_IDLE;
              end
              default: begin
                state_q <= S_OUT0;
              end
            endcase
          end
        end

        S_SEARCH: begin
          r_q <= unit_out;
          x_q <= x_q + 5'd1;
          if (search_end) begin
            invertible_q <= search_hit;
            inv_q        <= search_hit ? (x_q + 5'd1) : '0;
            if (decrypt_q && search_hit) begin
              state_q <= S_INV;
              pidx_q  <= 2'd0;
              bit_q   <= BitMsb;
            end else begin
              for (int i = 0; i < 4; i++) begin
                active_q[i] <= kr[i];
              end
              key_ready_q <= 1'b1;
              state_q     <= S_IDLE;
            end
          end
        end

        S_OUT0: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            letter_q    <= LetterBase + {2'b00, res_q[1]};
            status_q    <= STATUS_LETTER;
            last_q      <= 1'b0;
            state_q     <= S_OUT1;
          end
        end

        S_OUT1: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            letter_q    <= LetterBase + {2'b00, res_q[3]};
            status_q    <= STATUS_LETTER;
            last_q      <= pair_last_q;
            state_q     <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase

      // Key or mode register write: invalidate the active matrix and restart any preparation
      if (cfg_we_i) begin
        if (cfg_index_i == REG_DECRYPT) begin
          decrypt_q <= cfg_data_i[0];
        end else if ((cfg_index_i == REG_KEY_TL) || (cfg_index_i == REG_KEY_TR) ||
                     (cfg_index_i == REG_KEY_BL) || (cfg_index_i == REG_KEY_BR)) begin
          key_q[cfg_index_i[1:0]] <= cfg_data_i;
        end
        if (cfg_index_i <= REG_DECRYPT) begin
          key_ready_q <= 1'b0;
          if ((state_q == S_DET) || (state_q == S_SEARCH) || (state_q == S_INV)) begin
            state_q <= S_IDLE;
          end
        end
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign letter_code_o = letter_q;
  assign status_o      = status_q;
  assign last_o        = last_q;

`ifndef SYNTHESIS
  a_letter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == STATUS_LETTER)) |->
      ((letter_code_o >= 7'd65) && (letter_code_o <= 7'd90)))
    else $error("letter result outside A..Z");

  a_marker_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != STATUS_LETTER)) |-> ((letter_code_o == 7'd0) && last_o))
    else $error("end marker must carry letter 0 and last");

  a_prep_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DET) || (state_q == S_SEARCH) || (state_q == S_INV)) |-> !key_ready_q)
    else $error("key marked ready during preparation");

  a_search_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) |-> (x_q <= 5'd24))
    else $error("inverse search ran past 25 candidates");
`endif

endmodule

// File: sim/hcs_tb_pkg.sv
// Shared item codes, character bounds and the result record for the cipher testbench.
package hcs_tb_pkg;

  // Input item kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // ASCII letter bounds
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

  typedef struct packed {
    logic [6:0] letter;
    logic [1:0] status;
    logic       last;
  } cipher_result_t;

endpackage

// File: sim/hcs_cipher_checker.sv
// Watches the cipher channels, predicts every result and compares it with the block.
module hcs_cipher_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [4:0]  cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        kind_i,
  input  logic [7:0]  char_code_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [6:0]  letter_code_i,
  input  logic [1:0]  status_i,
  input  logic        last_i,
  output int unsigned pending_results_o,
  output int unsigned mismatch_count_o
);
  import hcs_pkg::*;
  import hcs_tb_pkg::*;

  localparam int unsigned Mod = int'(Modulus);

  logic [4:0]     key_reg [4];
  logic           decrypt_q;
  logic           held_valid;
  logic [4:0]     held_letter;
  logic [4:0]     matrix [4];
  logic           matrix_ready;
  logic           matrix_invertible;
  cipher_result_t cipher_results_q [$];
  int unsigned    mismatches;

  // Rebuild the matrix in use: the key itself, or its inverse mod 26 in decrypt mode.
  task automatic rebuild_matrix();
    int unsigned k [4];
    int unsigned det;
    int unsigned inv;
    inv = 0;
    for (int i = 0; i < 4; i++) k[i] = int'(key_reg[i]) % Mod;
    det = (k[0] * k[3] + Mod * Mod - k[1] * k[2]) % Mod;
    for (int x = 1; x < Mod; x++) begin
      if (inv == 0 && (det * x) % Mod == 1) inv = x;
    end
    matrix_invertible = (inv != 0);
    if (decrypt_q && matrix_invertible) begin
      matrix[0] = 5'((k[3] * inv) % Mod);
      matrix[1] = 5'(((Mod - k[1]) * inv) % Mod);
      matrix[2] = 5'(((Mod - k[2]) * inv) % Mod);
      matrix[3] = 5'((k[0] * inv) % Mod);
    end else begin
      for (int i = 0; i < 4; i++) matrix[i] = 5'(k[i]);
    end
    matrix_ready = 1'b1;
  endtask

  task automatic push_result(input int unsigned letter, input logic [1:0] status,
                             input logic last);
    cipher_result_t r;
    r.letter = 7'(letter);
    r.status = status;
    r.last   = last;
    cipher_results_q.push_back(r);
  endtask

  task automatic push_cipher_pair(input int unsigned p0, input int unsigned p1,
                                  input logic last);
    int unsigned c0;
    int unsigned c1;
    c0 = (matrix[0] * p0 + matrix[1] * p1) % Mod;
    c1 = (matrix[2] * p0 + matrix[3] * p1) % Mod;
    push_result(int'(LetterBase) + c0, STATUS_LETTER, 1'b0);
    push_result(int'(LetterBase) + c1, STATUS_LETTER, last);
  endtask

  task automatic predict_cipher_output(input logic kind, input logic [7:0] code);
    logic        blocked;
    logic        is_letter;
    int unsigned v;
    if (!matrix_ready) rebuild_matrix();
    blocked   = decrypt_q && !matrix_invertible;
    is_letter = 1'b1;
    v         = 0;
    if (kind == KIND_END) begin
      if (blocked) begin
        push_result(0, STATUS_BLOCKED, 1'b1);
      end else if (held_valid) begin
        push_cipher_pair(int'(held_letter), int'(PadLetter), 1'b1);
      end else begin
        push_result(0, STATUS_END, 1'b1);
      end
      held_valid  = 1'b0;
      held_letter = '0;
    end else begin
      if (code >= CHAR_UPPER_A && code <= CHAR_UPPER_Z) begin
        v = int'(code - CHAR_UPPER_A);
      end else if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z) begin
        v = int'(code - CHAR_LOWER_A);
      end else begin
        is_letter = 1'b0;
      end
      // a blocked key drops letters without touching the held one
      if (is_letter && !blocked) begin
        if (held_valid) begin
          push_cipher_pair(int'(held_letter), v, 1'b0);
          held_valid  = 1'b0;
          held_letter = '0;
        end else begin
          held_valid  = 1'b1;
          held_letter = 5'(v);
        end
      end
    end
  endtask

  task automatic note_mismatch(input string what, input cipher_result_t want);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t mismatch (%s): letter %0d/%0d status %0d/%0d last %0d/%0d (exp/act)",
               $time, what, want.letter, letter_code_i, want.status, status_i,
               want.last, last_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cipher_result_t want;
    if (!rst_ni) begin
      key_reg[0]        = KeyRstTl;
      key_reg[1]        = KeyRstTr;
      key_reg[2]        = KeyRstBl;
      key_reg[3]        = KeyRstBr;
      decrypt_q         = 1'b0;
      held_valid        = 1'b0;
      held_letter       = '0;
      for (int i = 0; i < 4; i++) matrix[i] = '0;
      matrix_ready      = 1'b0;
      matrix_invertible = 1'b0;
      mismatches        = 0;
      cipher_results_q.delete();
      pending_results_o <= 0;
      mismatch_count_o  <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (cipher_results_q.size() == 0) begin
          want = '0;
          note_mismatch("no result expected", want);
        end else begin
          want = cipher_results_q.pop_front();
          if (letter_code_i !== want.letter || status_i !== want.status ||
              last_i !== want.last) begin
            note_mismatch("wrong field", want);
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_index_i <= REG_KEY_BR) begin
          key_reg[cfg_index_i[1:0]] = cfg_data_i;
          matrix_ready              = 1'b0;
        end else if (cfg_index_i == REG_DECRYPT) begin
          decrypt_q    = cfg_data_i[0];
          matrix_ready = 1'b0;
        end
      end
      if (in_valid_i && !in_stall_i) predict_cipher_output(kind_i, char_code_i);
      pending_results_o <= cipher_results_q.size();
      mismatch_count_o  <= mismatches;
    end
  end

endmodule

// File: sim/tb_top.sv
// Stimulus, handshake pacing and verdict for the streaming 2x2 Hill cipher.
module tb_top;
  import hcs_pkg::*;
  import hcs_tb_pkg::*;

  // A character with no result is handled in the idle state; allow some margin.
  localparam int unsigned HoldOff       = 8;
  // Longest legal quiet stretch is a matrix rebuild plus a pair multiply plus
  // the longest stall and gap; allow a wide margin.
  localparam int unsigned IdleLimit     = 3000;
  localparam int unsigned RandomPhases  = 10;
  localparam int unsigned ItemsPerPhase = 70;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we      = 1'b0;
  logic [2:0] cfg_index   = '0;
  logic [4:0] cfg_data    = '0;
  logic       in_valid    = 1'b0;
  logic       kind        = KIND_CHAR;
  logic [7:0] char_code   = '0;
  logic       out_stall   = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [6:0] letter_code;
  logic [1:0] status;
  logic       last;

  // calm phases: neither side idles
  logic        calm = 1'b0;
  int unsigned stall_left;
  int unsigned idle_cycles;
  int unsigned results_seen;
  int unsigned pending_results;
  int unsigned mismatch_count;
  int unsigned chars_sent;
  int unsigned ends_sent;
  int unsigned cfg_writes;

  // what the registers hold, so that decrypt phases can favor usable keys
  logic [4:0] key_shadow [4];
  logic       decrypt_shadow;

  always #6 clk_i = ~clk_i;

  hill_cipher_2x2_stream dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .kind_i       (kind),
    .char_code_i  (char_code),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .letter_code_o(letter_code),
    .status_o     (status),
    .last_o       (last)
  );

  hcs_cipher_checker cipher_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .kind_i           (kind),
    .char_code_i      (char_code),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .letter_code_i    (letter_code),
    .status_i         (status),
    .last_i           (last),
    .pending_results_o(pending_results),
    .mismatch_count_o (mismatch_count)
  );

  // Output back-pressure: alternate runs of stall and flow, mostly short,
  // occasionally long; calm phases hold stall low.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (calm || $urandom_range(99) < 55) begin
      out_stall  <= 1'b0;
      stall_left <= calm ? 40 : $urandom_range(6);
    end else begin
      out_stall  <= 1'b1;
      stall_left <= ($urandom_range(99) < 90) ? $urandom_range(3) : $urandom_range(60, 20);
    end
  end

  // Watchdog: end the run if no transaction moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (out_valid && !out_stall) results_seen <= results_seen + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Timeout: no transaction for %0d cycles", IdleLimit);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one transaction, hold it until taken, then maybe idle for a while.
  // Valid stays high into the next item when no gap is drawn.
  task automatic send_item(input logic k, input logic [7:0] code);
    int unsigned gap;
    int unsigned roll;
    in_valid  <= 1'b1;
    kind      <= k;
    char_code <= code;
    do @(posedge clk_i); while (in_stall);
    if (k == KIND_END) ends_sent++;
    else chars_sent++;
    roll = $urandom_range(99);
    if (calm || roll < 55) gap = 0;
    else if (roll < 85) gap = $urandom_range(3, 1);
    else if (roll < 97) gap = $urandom_range(12, 4);
    else gap = $urandom_range(60, 20);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid and hold off until every predicted result has come back.
  // The first edge lets a count raised by the last transaction show up.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (HoldOff) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [4:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk_i);
    cfg_writes++;
    if (idx <= REG_KEY_BR) key_shadow[idx] = value;
    else if (idx == REG_DECRYPT) decrypt_shadow = value[0];
  endtask

  task automatic set_key(input logic [4:0] tl, input logic [4:0] tr, input logic [4:0] bl,
                         input logic [4:0] br, input logic decrypt);
    write_reg(REG_KEY_TL, tl);
    write_reg(REG_KEY_TR, tr);
    write_reg(REG_KEY_BL, bl);
    write_reg(REG_KEY_BR, br);
    write_reg(REG_DECRYPT, {4'b0000, decrypt});
    cfg_we <= 1'b0;
  endtask

  // A 2x2 key is usable for decryption when its determinant is a unit mod 26.
  function automatic bit key_has_inverse(input logic [4:0] k [4]);
    int unsigned det;
    det = ((k[0] % 26) * (k[3] % 26) + 676 - (k[1] % 26) * (k[2] % 26)) % 26;
    return (det % 2 == 1) && (det != 13);
  endfunction

  initial begin
    logic [4:0]  cand [4];
    logic        mask [4];
    logic        want_decrypt;
    logic        want_inv;
    logic [7:0]  code;
    int unsigned roll;

    key_shadow     = '{KeyRstTl, KeyRstTr, KeyRstBl, KeyRstBr};
    decrypt_shadow = 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset key, encrypt: letter extremes in both cases, non-letters right at
    // the letter boundaries and at the byte extremes, end with a lone letter
    // (padded) and end with nothing held.
    send_item(KIND_CHAR, "A");
    send_item(KIND_CHAR, "Z");
    send_item(KIND_CHAR, "a");
    send_item(KIND_CHAR, "z");
    send_item(KIND_CHAR, 8'h00);
    send_item(KIND_CHAR, 8'h40);
    send_item(KIND_CHAR, "M");
    send_item(KIND_CHAR, 8'h5B);
    send_item(KIND_CHAR, 8'h60);
    send_item(KIND_CHAR, 8'h7B);
    send_item(KIND_CHAR, 8'hFF);
    send_item(KIND_END, 8'hFF);
    send_item(KIND_END, 8'h00);

    // Hold a letter across a switch to decrypt; the reset key has no inverse,
    // so letters vanish and end reports the blocked key and drops the held one.
    send_item(KIND_CHAR, "K");
    wait_drained();
    write_reg(REG_DECRYPT, 5'd1);
    cfg_we <= 1'b0;
    send_item(KIND_CHAR, "B");
    send_item(KIND_END, 8'h5A);

    // Decrypt with an invertible key: one pair, then a padded odd letter.
    wait_drained();
    set_key(5'd3, 5'd3, 5'd2, 5'd5, 1'b1);
    send_item(KIND_CHAR, "H");
    send_item(KIND_CHAR, "I");
    send_item(KIND_CHAR, "N");
    send_item(KIND_END, 8'h00);

    // Held letter survives a key change; entries above 25 wrap mod 26 and a
    // singular key still encrypts.
    send_item(KIND_CHAR, "J");
    wait_drained();
    set_key(5'd31, 5'd27, 5'd26, 5'd30, 1'b0);
    send_item(KIND_CHAR, "L");
    send_item(KIND_END, 8'h80);

    // All-zero key in decrypt: blocked.
    wait_drained();
    set_key(5'd0, 5'd0, 5'd0, 5'd0, 1'b1);
    send_item(KIND_CHAR, "A");
    send_item(KIND_END, 8'h00);

    // All-25 key in encrypt, plus writes to indexes past the register list.
    wait_drained();
    set_key(5'd25, 5'd25, 5'd25, 5'd25, 1'b0);
    for (int i = REG_DECRYPT + 1; i < 8; i++) write_reg(3'(i), 5'd31);
    cfg_we <= 1'b0;
    send_item(KIND_CHAR, "Z");
    send_item(KIND_CHAR, "Z");
    send_item(KIND_END, 8'h00);

    // Random phases: each one gets a fresh setting, decrypt mostly with an
    // invertible key so that pairs get through, then mostly letters.
    for (int ph = 0; ph < RandomPhases; ph++) begin
      wait_drained();
      calm         <= (ph % 4 == 3);
      want_decrypt  = 1'($urandom_range(1));
      want_inv      = want_decrypt && ($urandom_range(99) < 80);
      do begin
        for (int i = 0; i < 4; i++) begin
          roll    = $urandom_range(99);
          mask[i] = want_inv || ($urandom_range(99) < 70);
          if (!mask[i]) cand[i] = key_shadow[i];
          else if (roll < 10) cand[i] = 5'd0;
          else if (roll < 20) cand[i] = 5'd25;
          else if (roll < 30) cand[i] = 5'($urandom_range(31, 26));
          else cand[i] = 5'($urandom_range(25));
        end
      end while (want_inv && !key_has_inverse(cand));
      for (int i = 0; i < 4; i++) begin
        if (mask[i]) write_reg(3'(i), cand[i]);
      end
      if ($urandom_range(99) < 70 || decrypt_shadow != want_decrypt) begin
        write_reg(REG_DECRYPT, {4'($urandom), want_decrypt});
      end
      if ($urandom_range(99) < 25) begin
        write_reg(3'($urandom_range(7, REG_DECRYPT + 1)), 5'($urandom));
      end
      cfg_we <= 1'b0;

      for (int n = 0; n < ItemsPerPhase; n++) begin
        roll = $urandom_range(99);
        if (roll < 10) begin
          send_item(KIND_END, 8'($urandom));
        end else if (roll < 22) begin
          do begin
            code = 8'($urandom);
          end while ((code >= CHAR_UPPER_A && code <= CHAR_UPPER_Z) ||
                     (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z));
          send_item(KIND_CHAR, code);
        end else if (roll < 61) begin
          send_item(KIND_CHAR, CHAR_UPPER_A + 8'($urandom_range(25)));
        end else begin
          send_item(KIND_CHAR, CHAR_LOWER_A + 8'($urandom_range(25)));
        end
        // now and then let the pipeline run dry mid-stream
        if ($urandom_range(99) < 2) wait_drained();
      end
    end

    wait_drained();
    repeat (30) @(posedge clk_i);

    $display("Sent %0d characters and %0d end-of-text items across %0d register writes,",
             chars_sent, ends_sent, cfg_writes);
    $display("checked %0d results over encrypt, decrypt and singular keys",
             results_seen);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatch_count, pending_results);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
